### rtl/x1024ss_pkg.sv
// Package for the xoroshiro1024** generator: shared types, operation codes,
// state-word geometry and the fixed rotate and shift amounts of the scheme.
// Depends on nothing; every other file in rtl imports it.
package x1024ss_pkg;

    localparam int WORD_W      = 64;
    localparam int WORD_COUNT  = 16;
    localparam int PTR_W       = 4;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 64;

    // Operation codes carried on the input tuser.
    localparam logic [OP_W-1:0] OP_GENERATE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 2'd1;
    localparam logic [OP_W-1:0] OP_POINTER  = 2'd2;

    // Rotate and shift amounts of the state update and of the scrambler.
    localparam int ROT_S0  = 25;
    localparam int SHL_T   = 27;
    localparam int ROT_T   = 36;
    localparam int ROT_OUT = 7;

    typedef enum logic [1:0] {
        KIND_GENERATE,
        KIND_LOAD,
        KIND_POINTER
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [PTR_W-1:0]   index;
        logic [WORD_W-1:0]  value;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIX,
        BK_WRITE_Q,
        BK_WRITE_P
    } back_state_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                 input int unsigned k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

endpackage

### rtl/x1024ss_front.sv
// Front end of the generator: takes input items, sorts them by operation,
// drops the unused code and holds the rest in a short queue for the back end.
// Depends on x1024ss_pkg.
module x1024ss_front
    import x1024ss_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // [3:0] word_index, [67:4] word_value, rest zero
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] operation
    output logic                  item_valid,
    output item_t                 item,
    input  logic                  item_pop
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg;
    logic [IDX_W-1:0]  wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg;
    logic [IDX_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    item_t             in_item;
    logic              keep;
    logic              push;

    always_comb
    begin
        in_item.index = s_tdata[PTR_W-1:0];
        in_item.value = s_tdata[PTR_W +: WORD_W];
        in_item.kind  = KIND_GENERATE;
        keep          = 1'b1;
        case (s_tuser)
            OP_GENERATE: in_item.kind = KIND_GENERATE;
            OP_LOAD:     in_item.kind = KIND_LOAD;
            OP_POINTER:  in_item.kind = KIND_POINTER;
            default:     keep = 1'b0;   // the unused code has no effect at all
        endcase
    end

    assign s_tready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready && keep;
    assign item_valid = (count_reg != '0);
    assign item       = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + IDX_W'(1);
        end
        if (item_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + IDX_W'(1);
        end
        if (push && !item_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && item_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/x1024ss_back.sv
// Back end of the generator: the sixteen-word state memory, the pointer,
// the xor/shift/rotate update, the ** scrambler and the output register.
// Depends on x1024ss_pkg.
module x1024ss_back
    import x1024ss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  item_t                  item,
    output logic                   item_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [63:0] random_value
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic [PTR_W-1:0]   q_addr_reg;
    logic [PTR_W-1:0]   p_addr_reg;
    logic [WORD_W-1:0]  word_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] written_reg;
    logic [WORD_W-1:0]  rd_p_reg;
    logic [WORD_W-1:0]  rd_q_reg;
    logic               rdv_p_reg;
    logic               rdv_q_reg;
    logic [WORD_W-1:0]  new_q_reg;
    logic [WORD_W-1:0]  new_p_reg;
    logic [WORD_W-1:0]  prod5_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [WORD_W-1:0]  out_data_reg;

    logic [PTR_W-1:0]   rd_addr_q;
    logic [PTR_W-1:0]   rd_addr_p;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               capture_addr;
    logic               mix_en;
    logic               load_out;
    logic               out_free;
    logic [WORD_W-1:0]  s0;
    logic [WORD_W-1:0]  s1;
    logic [WORD_W-1:0]  t;
    logic [WORD_W-1:0]  rot_prod;

    assign rd_addr_q = ptr_reg;
    assign rd_addr_p = ptr_reg + PTR_W'(1);
    assign out_free  = !out_valid_reg || m_tready;

    // Words never written since reset read as zero.
    assign s0       = rdv_p_reg ? rd_p_reg : '0;
    assign s1       = rdv_q_reg ? rd_q_reg : '0;
    assign t        = s1 ^ s0;
    assign rot_prod = rotl64(prod5_reg, ROT_OUT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (item_valid && item.kind == KIND_GENERATE)
                begin
                    state_next = BK_MIX;
                end
            end
            BK_MIX:     state_next = BK_WRITE_Q;
            BK_WRITE_Q:
            begin
                if (out_free)
                begin
                    state_next = BK_WRITE_P;
                end
            end
            BK_WRITE_P: state_next = BK_IDLE;
            default:    state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        item_pop     = 1'b0;
        capture_addr = 1'b0;
        mix_en       = 1'b0;
        load_out     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = q_addr_reg;
        wr_data      = new_q_reg;
        ptr_next     = ptr_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    case (item.kind)
                        KIND_GENERATE: capture_addr = 1'b1;
                        KIND_LOAD:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = item.index;
                            wr_data = item.value;
                        end
                        KIND_POINTER:  ptr_next = item.index;
                        default:       ;
                    endcase
                end
            end
            BK_MIX: mix_en = 1'b1;
            BK_WRITE_Q:
            begin
                // The old-pointer word and the result go out together once the
                // output register is free.
                if (out_free)
                begin
                    wr_en    = 1'b1;
                    load_out = 1'b1;
                end
            end
            BK_WRITE_P:
            begin
                wr_en    = 1'b1;
                wr_addr  = p_addr_reg;
                wr_data  = new_p_reg;
                ptr_next = p_addr_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            ptr_reg       <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // State memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= word_mem[rd_addr_q];
        rd_p_reg <= word_mem[rd_addr_p];
    end

    always_ff @(posedge clk)
    begin
        rdv_q_reg <= written_reg[rd_addr_q];
        rdv_p_reg <= written_reg[rd_addr_p];
        if (capture_addr)
        begin
            q_addr_reg <= rd_addr_q;
            p_addr_reg <= rd_addr_p;
        end
        if (mix_en)
        begin
            new_q_reg <= rotl64(s0, ROT_S0) ^ t ^ (t << SHL_T);
            new_p_reg <= rotl64(t, ROT_T);
            prod5_reg <= s0 + (s0 << 2);
        end
        if (load_out)
        begin
            out_data_reg <= rot_prod + (rot_prod << 3);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/xoroshiro1024_starstar_prng.sv
// xoroshiro1024** generator, top level: front queue plus back-end state engine.
// A generate is popped and its two words read, then mixed; the single write port then
// rewrites the old-pointer word as the value is registered, once the output is free,
// then the new-pointer word. One load or pointer item per cycle when the back end is idle.
// Reset (rst_n low, asynchronous) empties the queue, clears the pointer and
// marks every state word as zero; no sweep of the memory is needed.
module xoroshiro1024_starstar_prng
    import x1024ss_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [3:0] word_index, [67:4] word_value, rest zero
    input  logic [OP_W-1:0]        s_tuser,   // [1:0] operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [63:0] random_value
);

    logic  item_valid;
    logic  item_pop;
    item_t item;

    x1024ss_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    x1024ss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### rtl/x1024ss_checker.sv
// Port-level checks for the xoroshiro1024** generator, bound to the top level.
// Depends on x1024ss_pkg.
module x1024ss_checker
    import x1024ss_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A waiting result is neither withdrawn nor altered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Leaving reset, the queue is empty and no result is pending.
    assert property (@(posedge clk)
        $rose(rst_n) |-> s_tready && !m_tvalid)
        else $error("block not empty after reset");

    // A generate passes through the queue and the back-end states before its result is
    // registered, so no result can appear right after the first item accepted out of reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) ##1 (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind xoroshiro1024_starstar_prng x1024ss_checker u_checker (.*);

### verif/xoroshiro1024_starstar_prng_checker.sv
`timescale 1ns / 100ps
// Checker for the xoroshiro1024** generator: watches both stream channels, keeps its own
// copy of the sixteen state words and the pointer, and compares every random value.
// Depends on x1024ss_pkg for the operation codes and the channel widths.
module xoroshiro1024_starstar_prng_checker
    import x1024ss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     values_pending,
    output int                     values_checked
);

    localparam logic [WORD_W-1:0] MUL_PRE  = 64'd5;
    localparam logic [WORD_W-1:0] MUL_POST = 64'd9;

    logic [WORD_W-1:0] state_words [WORD_COUNT];
    logic [PTR_W-1:0]  state_ptr;
    logic [WORD_W-1:0] expected_values [$];

    function automatic logic [WORD_W-1:0] rotate_up(input logic [WORD_W-1:0] x,
                                                    input int unsigned k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

    // One generator step: scramble the word at the advanced pointer, then rewrite
    // the words at the old and the new pointer.
    task automatic advance_generator(output logic [WORD_W-1:0] value);
        logic [PTR_W-1:0]  old_ptr;
        logic [PTR_W-1:0]  new_ptr;
        logic [WORD_W-1:0] s0;
        logic [WORD_W-1:0] t;
        begin
            old_ptr = state_ptr;
            new_ptr = old_ptr + 1'b1;
            s0 = state_words[new_ptr];
            t = state_words[old_ptr] ^ s0;
            value = rotate_up(s0 * MUL_PRE, ROT_OUT) * MUL_POST;
            state_words[old_ptr] = rotate_up(s0, ROT_S0) ^ t ^ (t << SHL_T);
            state_words[new_ptr] = rotate_up(t, ROT_T);
            state_ptr = new_ptr;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        begin
            $display("mismatch at %0t: %s, got %h, want %h", $time, what, got, want);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] predicted;
        if (!rst_n)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
                state_words[i] = '0;
            state_ptr = '0;
            expected_values.delete();
            fail_count = 0;
            values_pending = 0;
            values_checked = 0;
        end
        else
        begin
            // The result leaving now always belongs to an older item than the one
            // entering, so it is compared before the new expectation is queued.
            if (m_tvalid && m_tready)
            begin
                values_checked++;
                if (expected_values.size() == 0)
                    report_mismatch("random_value with nothing expected", m_tdata, '0);
                else
                begin
                    predicted = expected_values.pop_front();
                    if (m_tdata[WORD_W-1:0] !== predicted)
                        report_mismatch("random_value", m_tdata, predicted);
                end
            end
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    OP_GENERATE:
                    begin
                        advance_generator(predicted);
                        expected_values.push_back(predicted);
                    end
                    OP_LOAD:    state_words[s_tdata[PTR_W-1:0]] = s_tdata[PTR_W +: WORD_W];
                    OP_POINTER: state_ptr = s_tdata[PTR_W-1:0];
                    default:    ;
                endcase
            end
            values_pending = expected_values.size();
        end
    end

endmodule

### verif/xoroshiro1024_starstar_prng_tb.sv
`timescale 1ns / 100ps
// Testbench top for the xoroshiro1024** generator: clock, reset, item stimulus with
// random idling on both channels, watchdog and verdict. Depends on x1024ss_pkg and the checker.
module xoroshiro1024_starstar_prng_tb;
    import x1024ss_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TOTAL     = 1750;
    localparam int CALM_TAIL      = 250;
    localparam int DRAIN_AT       = 1000;
    localparam int HOLD_AFTER     = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]        s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int values_pending;
    int values_checked;
    int items_sent;
    int quiet_cycles;
    bit calm;

    xoroshiro1024_starstar_prng dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    xoroshiro1024_starstar_prng_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .values_pending (values_pending),
        .values_checked (values_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned roll;
        begin
            roll = $urandom_range(0, 15);
            if (roll == 0)
                return '0;
            if (roll == 1)
                return '1;
            return {$urandom, $urandom};
        end
    endfunction

    // Offers one item, possibly after an idle burst, and returns at the falling
    // edge after it has been taken.
    task automatic offer_item(input logic [OP_W-1:0] op, input logic [PTR_W-1:0] index,
                              input logic [WORD_W-1:0] value);
        int unsigned gap;
        begin
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 19);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= op;
            s_tdata  <= {{(IN_TDATA_W - WORD_W - PTR_W){1'b0}}, value, index};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            items_sent++;
            calm = (items_sent >= ITEM_TOTAL - CALM_TAIL);
            @(negedge clk);
        end
    endtask

    task automatic reseed_all();
        begin
            for (int i = 0; i < WORD_COUNT; i++)
                offer_item(OP_LOAD, i[PTR_W-1:0], pick_word());
        end
    endtask

    // Receiver: random stalls, plus one long hold-off so that the block backs up.
    initial
    begin
        int unsigned stall_left;
        bit held;
        stall_left = 0;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && values_checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned roll;
        bit drained;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_GENERATE;
        items_sent = 0;
        calm = 1'b0;
        drained = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Straight after reset the state is all zero, so the generator gives zero;
        // the unused fields carry junk that must be ignored.
        offer_item(OP_GENERATE, 4'hf, '1);
        offer_item(OP_GENERATE, 4'h5, 64'ha5a5_5a5a_0f0f_f0f0);
        offer_item(OP_UNUSED, 4'h3, '1);
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            if (i == 3)
                offer_item(OP_LOAD, i[PTR_W-1:0], '0);
            else if (i == 7)
                offer_item(OP_LOAD, i[PTR_W-1:0], '1);
            else
                offer_item(OP_LOAD, i[PTR_W-1:0], {$urandom, $urandom});
        end
        // Pointer at the top so that the next step wraps round to word zero.
        offer_item(OP_POINTER, 4'hf, '1);
        offer_item(OP_GENERATE, '0, '0);
        offer_item(OP_POINTER, 4'h0, 64'hdead_beef_cafe_f00d);
        offer_item(OP_GENERATE, 4'ha, '1);
        offer_item(OP_GENERATE, 4'h0, '0);

        while (items_sent < ITEM_TOTAL)
        begin
            if (!drained && items_sent >= DRAIN_AT)
            begin
                drained = 1'b1;
                s_tvalid <= 1'b0;
                @(negedge clk);
                while (values_pending != 0)
                    @(negedge clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                reseed_all();
            else if (roll < 80)
                offer_item(OP_GENERATE, PTR_W'($urandom_range(0, 15)), pick_word());
            else if (roll < 90)
                offer_item(OP_LOAD, PTR_W'($urandom_range(0, 15)), pick_word());
            else if (roll < 97)
                offer_item(OP_POINTER, PTR_W'($urandom_range(0, 15)), pick_word());
            else
                offer_item(OP_UNUSED, PTR_W'($urandom_range(0, 15)), pick_word());
        end
        s_tvalid <= 1'b0;

        while (values_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/x1024ss_pkg.sv
rtl/x1024ss_front.sv
rtl/x1024ss_back.sv
rtl/xoroshiro1024_starstar_prng.sv
rtl/x1024ss_checker.sv
verif/xoroshiro1024_starstar_prng_checker.sv
verif/xoroshiro1024_starstar_prng_tb.sv
